>>> src/save_image_region_checksum_check_core_assert.svh
// Assertion macros for the save image region checksum checker.
// Included by the top level; depends on no other file.
`ifndef SAVE_IMAGE_REGION_CHECKSUM_CHECK_CORE_ASSERT_SVH
`define SAVE_IMAGE_REGION_CHECKSUM_CHECK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is low
`define SIRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sirc assertion failed");
// Clocked assertion that is checked during reset as well
`define SIRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sirc assertion failed");
`else
`define SIRC_ASSERT(lbl, clk, rst_n, prop)
`define SIRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/sirc_pkg.sv
// Shared types, constants and helpers for the save image region checksum checker.
// Used by sirc_scan and the top level; depends on nothing.
package sirc_pkg;

    localparam int unsigned IMAGE_BYTES_DEF = 512;
    localparam int unsigned POS_W           = 10;
    localparam int unsigned REGION_COUNT    = 6;
    localparam int unsigned FAIL_W          = 3;

    localparam logic [FAIL_W-1:0] NO_FAILURE = 3'd6;
    localparam logic [16:0]       ADLER_MOD  = 17'd65521;

    // First byte of each big-endian stored checksum (four bytes, word aligned)
    localparam logic [POS_W-1:0] SUM_OFFSET [REGION_COUNT] =
        '{10'h000, 10'h010, 10'h024, 10'h020, 10'h0EC, 10'h0E8};
    // First and last byte of each checked data region
    localparam logic [POS_W-1:0] REGION_FIRST [REGION_COUNT] =
        '{10'h004, 10'h014, 10'h028, 10'h038, 10'h0F0, 10'h100};
    localparam logic [POS_W-1:0] REGION_LAST [REGION_COUNT] =
        '{10'h00F, 10'h01F, 10'h037, 10'h0E7, 10'h0FF, 10'h1AF};

    // Per-image outcome handed from the scanner to the output register
    typedef struct packed {
        logic              length_wrong;
        logic [FAIL_W-1:0] failed_region;
        logic              image_valid;
    } t_scan_result;

    // Add two residues and fold back below the modulus with one subtract
    function automatic logic [15:0] mod_add(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= ADLER_MOD) begin
            s = s - ADLER_MOD;
        end
        return s[15:0];
    endfunction

endpackage

>>> src/sirc_scan.sv
// Image scanner: byte position, running Adler sums, stored checksums, first failure.
// Depends on sirc_pkg.
module sirc_scan #(
    parameter int unsigned IMAGE_BYTES = sirc_pkg::IMAGE_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [7:0]              i_byte,
    input  logic                    i_final,
    output sirc_pkg::t_scan_result  o_result
);

    localparam logic [sirc_pkg::POS_W-1:0] LAST_POS    = sirc_pkg::POS_W'(IMAGE_BYTES - 1);
    localparam logic [sirc_pkg::POS_W-1:0] IMAGE_LIMIT = sirc_pkg::POS_W'(IMAGE_BYTES);

    logic [sirc_pkg::POS_W-1:0]  r_pos;
    logic [15:0]                 r_sum_low;
    logic [15:0]                 r_sum_high;
    logic [31:0]                 r_stored [sirc_pkg::REGION_COUNT];
    logic [sirc_pkg::FAIL_W-1:0] r_first_fail;
    logic                        r_len_err;

    logic                                pos_ok;
    logic [sirc_pkg::REGION_COUNT-1:0]   cap;
    logic [sirc_pkg::REGION_COUNT-1:0]   in_reg;
    logic [sirc_pkg::REGION_COUNT-1:0]   at_end;
    logic [15:0]                         sum_low_add;
    logic [15:0]                         sum_high_add;
    logic                                mismatch;
    logic [sirc_pkg::FAIL_W-1:0]         end_idx;
    logic [sirc_pkg::FAIL_W-1:0]         n_first_fail;
    logic                                wrong;

    // Decode the current position against the fixed layout
    always_comb begin
        pos_ok = (r_pos < IMAGE_LIMIT);
        for (int k = 0; k < sirc_pkg::REGION_COUNT; k++) begin
            cap[k]    = pos_ok && (r_pos[sirc_pkg::POS_W-1:2] ==
                                   sirc_pkg::SUM_OFFSET[k][sirc_pkg::POS_W-1:2]);
            in_reg[k] = pos_ok && (r_pos >= sirc_pkg::REGION_FIRST[k]) &&
                        (r_pos <= sirc_pkg::REGION_LAST[k]);
            at_end[k] = pos_ok && (r_pos == sirc_pkg::REGION_LAST[k]);
        end
    end

    // Advance both sums and compare at a region's last byte
    always_comb begin
        sum_low_add  = sirc_pkg::mod_add(r_sum_low, {8'd0, i_byte});
        sum_high_add = sirc_pkg::mod_add(r_sum_high, sum_low_add);
        mismatch     = 1'b0;
        end_idx      = '0;
        for (int k = 0; k < sirc_pkg::REGION_COUNT; k++) begin
            if (at_end[k]) begin
                end_idx = sirc_pkg::FAIL_W'(k);
                if ({sum_high_add, sum_low_add} != r_stored[k]) begin
                    mismatch = 1'b1;
                end
            end
        end
        n_first_fail = (r_first_fail == sirc_pkg::NO_FAILURE && mismatch) ?
                       end_idx : r_first_fail;
        wrong        = r_len_err || (r_pos != LAST_POS);
    end

    // Outcome if the current item closes the image
    assign o_result.image_valid   = !wrong && (n_first_fail == sirc_pkg::NO_FAILURE);
    assign o_result.failed_region = n_first_fail;
    assign o_result.length_wrong  = wrong;

    // Update scan state; a final item returns everything to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_final)) begin
            r_pos        <= '0;
            r_sum_low    <= 16'd1;
            r_sum_high   <= '0;
            r_first_fail <= sirc_pkg::NO_FAILURE;
            r_len_err    <= 1'b0;
            for (int k = 0; k < sirc_pkg::REGION_COUNT; k++) begin
                r_stored[k] <= '0;
            end
        end else if (i_take) begin
            if (pos_ok) begin
                r_pos <= r_pos + 1'b1;
            end else begin
                r_len_err <= 1'b1;
            end
            for (int k = 0; k < sirc_pkg::REGION_COUNT; k++) begin
                if (cap[k]) begin
                    r_stored[k] <= {r_stored[k][23:0], i_byte};
                end
            end
            if (|in_reg) begin
                if (|at_end) begin
                    r_sum_low  <= 16'd1;
                    r_sum_high <= '0;
                end else begin
                    r_sum_low  <= sum_low_add;
                    r_sum_high <= sum_high_add;
                end
            end
            r_first_fail <= n_first_fail;
        end
    end

endmodule

>>> src/save_image_region_checksum_check_core.sv
// Save image region checksum checker: one byte per cycle, one verdict per image.
// The final byte is held in the input register, and its verdict is then loaded into the output register.
// Throughput: one byte per cycle, set by the combinational Adler update in sirc_scan;
// a final byte waits in the input register only while the previous verdict is held.
// Reset: synchronous active-low i_rst_n empties both registers and restarts the image.
// Depends on sirc_pkg, sirc_scan and save_image_region_checksum_check_core_assert.svh.
`include "save_image_region_checksum_check_core_assert.svh"
module save_image_region_checksum_check_core #(
    parameter int unsigned IMAGE_BYTES = sirc_pkg::IMAGE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] image_byte
    input  logic       i_s_axis_tlast,   // final_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] image_valid, [3:1] failed_region,
                                         // [4] length_wrong, [7:5] zero
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_final;
    logic                   r_out_valid;
    sirc_pkg::t_scan_result r_out_result;

    logic                   advance;
    sirc_pkg::t_scan_result scan_result;

    // Only a final item needs room in the output register
    assign advance         = r_in_valid && (!r_in_final || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Hold the accepted item in the input register until the scanner takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_final <= i_s_axis_tlast;
        end
    end

    sirc_scan #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (advance),
        .i_byte   (r_in_byte),
        .i_final  (r_in_final),
        .o_result (scan_result)
    );

    // Load the verdict on a final item, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_final) begin
            r_out_result <= scan_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_result.length_wrong,
                              r_out_result.failed_region, r_out_result.image_valid};

    // A new verdict appears only after a final item was processed
    `SIRC_ASSERT(a_out_after_final, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(advance && r_in_final))
    // A stalled item in the input register is kept
    `SIRC_ASSERT(a_in_held, i_clk, i_rst_n,
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_final)))
    // A good image carries no failing region and a correct length
    `SIRC_ASSERT(a_valid_consistent, i_clk, i_rst_n,
        (r_out_valid && r_out_result.image_valid) |->
        (r_out_result.failed_region == sirc_pkg::NO_FAILURE && !r_out_result.length_wrong))

endmodule

>>> tb/tb_save_image_region_checksum_check_core.sv
// Testbench for save_image_region_checksum_check_core: streams whole save images and
// checks each verdict against a local Adler-32 region scanner.
// Depends only on the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module tb_save_image_region_checksum_check_core;

    // Image layout as seen by the block
    localparam int unsigned IMAGE_LEN   = 512;
    localparam int unsigned NUM_REGIONS = 6;
    localparam logic [16:0] ADLER_BASE  = 17'd65521;
    localparam logic [2:0]  NONE_FAILED = 3'd6;

    localparam int unsigned SUM_AT    [NUM_REGIONS] = '{'h000, 'h010, 'h024, 'h020, 'h0EC, 'h0E8};
    localparam int unsigned REG_FIRST [NUM_REGIONS] = '{'h004, 'h014, 'h028, 'h038, 'h0F0, 'h100};
    localparam int unsigned REG_LAST  [NUM_REGIONS] = '{'h00F, 'h01F, 'h037, 'h0E7, 'h0FF, 'h1AF};

    localparam int unsigned TAIL_CYCLES = 8;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        logic       length_wrong;
        logic [2:0] failed_region;
        logic       image_valid;
    } t_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;

    save_image_region_checksum_check_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] image_byte
        .i_s_axis_tlast  (s_tlast),   // final_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // [0] image_valid, [3:1] failed_region,
                                      // [4] length_wrong, [7:5] zero
    );

    // Scanner state mirrored by the predictor
    int unsigned scan_pos;
    logic [15:0] acc_a;
    logic [15:0] acc_b;
    logic [31:0] stored_sum [NUM_REGIONS];
    logic [2:0]  first_fail;
    logic        len_err;

    t_verdict    verdict_q [$];
    logic [7:0]  frame [$];

    int unsigned burst_left;
    int unsigned items_sent;
    int unsigned images_sent;
    int unsigned verdicts_seen;
    int unsigned mismatches;
    int unsigned unexpected;
    int unsigned leftover;

    int unsigned stall_mode;
    int unsigned stall_left;

    t_verdict    want;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20ms;
        $display("Timeout with %0d verdicts outstanding", verdict_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // Adler add with one conditional subtract
    function automatic logic [15:0] adler_fold(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= ADLER_BASE) begin
            s = s - ADLER_BASE;
        end
        return s[15:0];
    endfunction

    task automatic clear_scan();
        scan_pos   = 0;
        acc_a      = 16'd1;
        acc_b      = 16'd0;
        first_fail = NONE_FAILED;
        len_err    = 1'b0;
        for (int k = 0; k < NUM_REGIONS; k++) begin
            stored_sum[k] = 32'd0;
        end
    endtask

    // Advance the scanner by one accepted item and queue a verdict on the last one
    task automatic predict_item(input logic [7:0] data, input logic last);
        int unsigned p;
        logic        wrong;
        t_verdict    v;
        p = scan_pos;
        if (p >= IMAGE_LEN) begin
            len_err = 1'b1;
        end else begin
            for (int k = 0; k < NUM_REGIONS; k++) begin
                if (p >= SUM_AT[k] && p < SUM_AT[k] + 4) begin
                    stored_sum[k] = {stored_sum[k][23:0], data};
                end
            end
            for (int k = 0; k < NUM_REGIONS; k++) begin
                if (p >= REG_FIRST[k] && p <= REG_LAST[k]) begin
                    acc_a = adler_fold(acc_a, {8'd0, data});
                    acc_b = adler_fold(acc_b, acc_a);
                    if (p == REG_LAST[k]) begin
                        if ({acc_b, acc_a} != stored_sum[k] && first_fail == NONE_FAILED) begin
                            first_fail = 3'(k);
                        end
                        acc_a = 16'd1;
                        acc_b = 16'd0;
                    end
                end
            end
            scan_pos = p + 1;
        end
        if (last) begin
            wrong           = len_err || (p != IMAGE_LEN - 1);
            v.image_valid   = !wrong && (first_fail == NONE_FAILED);
            v.failed_region = first_fail;
            v.length_wrong  = wrong;
            verdict_q       = {verdict_q, v};
            clear_scan();
        end
    endtask

    // Send one item; bursts of random length separated by random gaps
    task automatic send_item(input logic [7:0] data, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_item(data, last);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stream the frame buffer as one image, marking its last item
    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) begin
            send_item(frame[i], i == frame.size() - 1);
        end
        images_sent++;
    endtask

    // Wait until every verdict is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Fill a full-length image and write the correct stored sums
    task automatic build_good_frame(input t_fill fill);
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] sum;
        frame.delete();
        for (int i = 0; i < IMAGE_LEN; i++) begin
            case (fill)
                FILL_ZERO: frame = {frame, 8'h00};
                FILL_ONES: frame = {frame, 8'hFF};
                default:   frame = {frame, 8'($urandom_range(0, 255))};
            endcase
        end
        for (int k = 0; k < NUM_REGIONS; k++) begin
            a = 16'd1;
            b = 16'd0;
            for (int i = REG_FIRST[k]; i <= REG_LAST[k]; i++) begin
                a = adler_fold(a, {8'd0, frame[i]});
                b = adler_fold(b, a);
            end
            sum = {b, a};
            for (int i = 0; i < 4; i++) begin
                frame[SUM_AT[k] + i] = sum[31 - 8*i -: 8];
            end
        end
    endtask

    task automatic build_noise_frame(input int unsigned len);
        frame.delete();
        for (int i = 0; i < len; i++) begin
            frame = {frame, 8'($urandom_range(0, 255))};
        end
    endtask

    // Flip some bits of one item in the frame
    task automatic corrupt_at(input int unsigned idx);
        frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic corrupt_region(input int unsigned k);
        corrupt_at($urandom_range(REG_FIRST[k], REG_LAST[k]));
    endtask

    task automatic append_noise(input int unsigned count);
        for (int i = 0; i < count; i++) begin
            frame = {frame, 8'($urandom_range(0, 255))};
        end
    endtask

    // Directed: one-item and two-item images, the shortest possible
    task automatic test_tiny_images();
        frame = '{8'h00};
        send_frame();
        frame = '{8'hFF};
        send_frame();
        frame = '{8'hA5, 8'h5A};
        send_frame();
        drain();
    endtask

    // Directed: intact images with extreme and random content
    task automatic test_intact_images();
        build_good_frame(FILL_ZERO);
        send_frame();
        build_good_frame(FILL_ONES);
        send_frame();
        build_good_frame(FILL_RANDOM);
        send_frame();
        drain();
    endtask

    // Directed: each region failing alone, a bad stored sum, several at once, no stored sums
    task automatic test_region_failures();
        for (int k = 0; k < NUM_REGIONS; k++) begin
            build_good_frame(FILL_RANDOM);
            corrupt_region(k);
            send_frame();
        end
        // bad stored sum instead of bad data
        build_good_frame(FILL_RANDOM);
        corrupt_at(SUM_AT[5] + 3);
        send_frame();
        // lowest failing index wins
        build_good_frame(FILL_ONES);
        corrupt_region(4);
        corrupt_region(2);
        send_frame();
        // no stored sums at all: the first region fails
        frame.delete();
        for (int i = 0; i < IMAGE_LEN; i++) frame = {frame, 8'h00};
        send_frame();
        drain();
    endtask

    // Directed: images cut short at region boundaries and one item before the end
    task automatic test_short_images();
        build_good_frame(FILL_RANDOM);
        corrupt_region(0);
        frame = frame[0:REG_LAST[0]];
        send_frame();
        build_good_frame(FILL_RANDOM);
        corrupt_region(3);
        frame = frame[0:REG_LAST[2]];
        send_frame();
        build_good_frame(FILL_RANDOM);
        frame = frame[0:REG_LAST[5]];
        send_frame();
        build_good_frame(FILL_ONES);
        frame = frame[0:IMAGE_LEN-2];
        send_frame();
        drain();
    endtask

    // Directed: images running past the end, one far past the position range
    task automatic test_overlong_images();
        build_good_frame(FILL_RANDOM);
        append_noise(1);
        send_frame();
        build_good_frame(FILL_RANDOM);
        corrupt_region(3);
        append_noise(5);
        send_frame();
        build_good_frame(FILL_ZERO);
        append_noise(600);
        send_frame();
        build_good_frame(FILL_RANDOM);
        send_frame();
        drain();
    endtask

    // Random: mostly well-formed images, plus corrupted, short, long and noise
    task automatic test_random_images();
        int unsigned start_items;
        int unsigned pick;
        int unsigned hits;
        start_items = items_sent;
        while (items_sent - start_items < 550) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                build_good_frame(($urandom_range(0, 9) == 0) ? FILL_ONES : FILL_RANDOM);
                if ($urandom_range(0, 1) == 1) begin
                    hits = $urandom_range(1, 3);
                    for (int i = 0; i < hits; i++) begin
                        if ($urandom_range(0, 1) == 1) corrupt_region($urandom_range(0, 5));
                        else corrupt_at($urandom_range(0, IMAGE_LEN - 1));
                    end
                end
            end else if (pick < 80) begin
                build_good_frame(FILL_RANDOM);
                if ($urandom_range(0, 2) == 0) corrupt_region($urandom_range(0, 5));
                frame = frame[0:$urandom_range(0, IMAGE_LEN - 2)];
            end else if (pick < 90) begin
                build_good_frame(FILL_RANDOM);
                append_noise($urandom_range(1, 40));
            end else if (pick < 95) begin
                build_noise_frame(IMAGE_LEN);
            end else begin
                build_noise_frame($urandom_range(1, 8));
            end
            send_frame();
        end
        drain();
    endtask

    // Receiver readiness: switch between always ready, random, sparse and long stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (stall_left < 4);
        endcase
    end

    task automatic report_field(input string field, input int unsigned exp_v, input int unsigned got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch on verdict %0d, %s: expected %0d, got %0d",
                     verdicts_seen, field, exp_v, got_v);
        end
    endtask

    // Compare each accepted verdict with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                unexpected++;
                $display("Verdict 0x%02h with nothing expected", m_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.image_valid)
                    report_field("image_valid", want.image_valid, m_tdata[0]);
                if (m_tdata[3:1] !== want.failed_region)
                    report_field("failed_region", want.failed_region, m_tdata[3:1]);
                if (m_tdata[4] !== want.length_wrong)
                    report_field("length_wrong", want.length_wrong, m_tdata[4]);
                if (m_tdata[7:5] !== 3'd0)
                    report_field("padding", 0, m_tdata[7:5]);
            end
            verdicts_seen++;
        end
    end

    // Test sequence
    initial begin
        burst_left    = 0;
        items_sent    = 0;
        images_sent   = 0;
        verdicts_seen = 0;
        mismatches    = 0;
        unexpected    = 0;
        leftover      = 0;
        stall_mode    = 0;
        stall_left    = 0;
        clear_scan();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_tiny_images();
        test_intact_images();
        test_region_failures();
        test_short_images();
        test_overlong_images();
        test_random_images();

        leftover = verdict_q.size();
        $display("Sent %0d images in %0d items: intact, corrupted, short, overlong and noise",
                 images_sent, items_sent);
        $display("Checked %0d verdicts: %0d field mismatches, %0d unexpected, %0d missing",
                 verdicts_seen, mismatches, unexpected, leftover);
        if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
